/* sv/assert_macros.svh */
// assertion macros shared by the rpn evaluator rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property that must hold whenever not in reset
`define ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error("%m: check failed");
// implication whose consequent is checked in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error("%m: check failed");
`endif

/* sv/rpn_pkg.sv */
// types and codes for the rpn stack evaluator
// no dependencies
package rpn_pkg;
   localparam logic [2:0] OP_PUSH = 3'd0;
   localparam logic [2:0] OP_ADD  = 3'd1;
   localparam logic [2:0] OP_SUB  = 3'd2;
   localparam logic [2:0] OP_MUL  = 3'd3;
   localparam logic [2:0] OP_DIV  = 3'd4;
   localparam logic [2:0] OP_POW  = 3'd5;
   localparam logic [2:0] OP_NEG  = 3'd6;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_ANSWER    = 3'd1;
   localparam logic [2:0] ST_DIVZERO   = 3'd2;
   localparam logic [2:0] ST_DEPTH     = 3'd3;
   localparam logic [2:0] ST_OVERFLOW  = 3'd4;
   localparam logic [2:0] ST_UNDERFLOW = 3'd5;

   typedef enum logic [3:0] {
      S_IDLE, S_RD1, S_RD2, S_EXEC, S_MUL, S_DIV, S_PSTEP, S_PMUL, S_PREC, S_WB, S_RESP
   } state_type;
endpackage

/* sv/rpn_stack_evaluator_core.sv */
// rpn stack evaluator top level: operand stack, shared mul and divide unit, sequencer
// depends on rpn_pkg and assert_macros.svh
//
//  channel  dir  ports                       payload
//  req      in   req_tvalid/tready/tdata     op[2:0], operand[34:3]; tlast final_token
//  rsp      out  rsp_tvalid/tready/tdata     answer[31:0], status[34:32]
//
// states from accept to ready again: no-op or faulted item S_RESP; push S_WB, S_RESP;
// add/subtract/negate S_RD1, S_RD2, S_EXEC, S_WB, S_RESP; multiply adds S_MUL after S_EXEC
// divide: one quotient bit per cycle through the shared divider
// power: up to two shared multiplies per exponent bit, then the divider if the reciprocal is needed
// reset is synchronous and clears depth, error and handshake state
// a result waits in the output register; the next item is taken meanwhile, but its
// response stalls until rsp frees the register
`include "assert_macros.svh"
module rpn_stack_evaluator_core #(
   parameter int STACK_DEPTH = 16,
   parameter int FRAC_BITS   = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // op[2:0], operand[34:3], zero fill
   input  logic        req_tlast,   // final_token
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // answer[31:0], status[34:32], zero fill
);
   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int DW = $clog2(STACK_DEPTH + 1);
   localparam logic [63:0] MAG_CAP = 64'h8000_0000;
   localparam logic [63:0] Q_ONE   = 64'd1 << FRAC_BITS;

   rpn_pkg::state_type state_ff, state_in;
   logic [DW-1:0] depth_ff, depth_in;
   logic [2:0]    err_ff, err_in;
   logic [2:0]    op_ff, op_in;
   logic [31:0]   opnd_ff, opnd_in;
   logic          last_ff, last_in;
   logic [31:0]   x_ff, x_in, y_ff, y_in;
   logic [63:0]   base_ff, base_in, acc_ff, acc_in;
   logic [31:0]   exp_ff, exp_in;
   logic          neg_ff, neg_in, recip_ff, recip_in;
   logic [31:0]   res_ff, res_in;
   logic [39:0]   out_ff, out_in;
   logic          ovalid_ff, ovalid_in;
   // shared unit operands and mode
   logic [63:0]   ua_ff, ua_in, ub_ff, ub_in;
   logic [1:0]    dst_ff, dst_in;   // 0 acc, 1 base, 2 result
   logic [63:0]   rem_ff, rem_in, quo_ff, quo_in, num_ff, num_in;
   logic [6:0]    cnt_ff, cnt_in;

   // stack memory, a write in the same cycle is seen by the read
   logic [31:0]   stack_mem [STACK_DEPTH];
   logic [31:0]   rd_ff;
   logic [AW-1:0] rd_addr, wr_addr;
   logic          wr_en;
   logic [31:0]   wr_data;

   always_ff @(posedge clock) begin
      if (wr_en) stack_mem[wr_addr] <= wr_data;
      rd_ff <= (wr_en && (wr_addr == rd_addr)) ? wr_data : stack_mem[rd_addr];
   end

   // saturating magnitude with sign
   function automatic logic [31:0] sign_cap(input logic neg, input logic [63:0] m);
      logic [63:0] c;
      c = (m > MAG_CAP) ? MAG_CAP : m;
      if (neg) return 32'(~c + 64'd1);
      if (c > 64'h7FFF_FFFF) return 32'h7FFF_FFFF;
      return c[31:0];
   endfunction

   function automatic logic [31:0] sat33(input logic [32:0] v);
      if (v[32] != v[31]) return v[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      return v[31:0];
   endfunction

   function automatic logic [63:0] mag(input logic [31:0] v);
      logic [32:0] n;
      n = v[31] ? -{v[31], v} : {1'b0, v};
      return {31'd0, n};
   endfunction

   logic [63:0] prod;     // one 32x32 multiply, operands capped at 2^31
   logic [63:0] mul_res;
   logic [64:0] rsh;
   logic [1:0]  unused_prod;

   assign prod = ua_ff[31:0] * ub_ff[31:0];
   assign mul_res = ((ua_ff[32] ? {ub_ff[31:0], 32'd0} : 64'd0) |
                     (ub_ff[32] ? {ua_ff[31:0], 32'd0} : 64'd0) |
                     (ua_ff[32] && ub_ff[32] ? 64'd0 : prod)) >> FRAC_BITS;
   assign rsh = {rem_ff, num_ff[63]};
   assign unused_prod = {ua_ff[63], ub_ff[63]};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= rpn_pkg::S_IDLE;
         depth_ff  <= '0;
         err_ff    <= rpn_pkg::ST_OK;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         depth_ff  <= depth_in;
         err_ff    <= err_in;
         ovalid_ff <= ovalid_in;
      end
      op_ff <= op_in;   opnd_ff <= opnd_in; last_ff <= last_in;
      x_ff <= x_in;     y_ff <= y_in;       base_ff <= base_in;
      acc_ff <= acc_in; exp_ff <= exp_in;   neg_ff <= neg_in;
      recip_ff <= recip_in; res_ff <= res_in; out_ff <= out_in;
      ua_ff <= ua_in;   ub_ff <= ub_in;     dst_ff <= dst_in;
      rem_ff <= rem_in; quo_ff <= quo_in;   num_ff <= num_in; cnt_ff <= cnt_in;
   end

   assign req_tready = (state_ff == rpn_pkg::S_IDLE);
   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = out_ff;

   always_comb begin
      logic [63:0] capped;
      logic [63:0] rem_try;
      logic [63:0] ymag;
      state_in = state_ff; depth_in = depth_ff; err_in = err_ff;
      op_in = op_ff; opnd_in = opnd_ff; last_in = last_ff;
      x_in = x_ff; y_in = y_ff; base_in = base_ff; acc_in = acc_ff;
      exp_in = exp_ff; neg_in = neg_ff; recip_in = recip_ff; res_in = res_ff;
      out_in = out_ff; ovalid_in = ovalid_ff;
      ua_in = ua_ff; ub_in = ub_ff; dst_in = dst_ff;
      rem_in = rem_ff; quo_in = quo_ff; num_in = num_ff; cnt_in = cnt_ff;
      rd_addr = AW'(depth_ff - DW'(1)); wr_addr = AW'(depth_ff); wr_en = 1'b0; wr_data = opnd_ff;
      capped = (mul_res > MAG_CAP) ? MAG_CAP : mul_res;
      rem_try = rsh[63:0] - ub_ff;
      ymag = mag(y_ff);
      if (ovalid_ff && rsp_tready) ovalid_in = 1'b0;
      case (state_ff)
         // take an item and check depth
         rpn_pkg::S_IDLE: begin
            if (req_tvalid && req_tready) begin
               op_in = req_tdata[2:0]; opnd_in = req_tdata[34:3]; last_in = req_tlast;
               state_in = rpn_pkg::S_RESP;
               if (err_ff == rpn_pkg::ST_OK) begin
                  case (req_tdata[2:0])
                     rpn_pkg::OP_PUSH: begin
                        if (32'(depth_ff) >= STACK_DEPTH) err_in = rpn_pkg::ST_OVERFLOW;
                        else state_in = rpn_pkg::S_WB;
                     end
                     rpn_pkg::OP_NEG: begin
                        if (depth_ff == '0) err_in = rpn_pkg::ST_UNDERFLOW;
                        else state_in = rpn_pkg::S_RD1;
                     end
                     rpn_pkg::OP_ADD, rpn_pkg::OP_SUB, rpn_pkg::OP_MUL,
                     rpn_pkg::OP_DIV, rpn_pkg::OP_POW: begin
                        if (depth_ff < DW'(2)) err_in = rpn_pkg::ST_UNDERFLOW;
                        else state_in = rpn_pkg::S_RD1;
                     end
                     default: ;
                  endcase
               end
            end
         end
         // top arrives, then second
         rpn_pkg::S_RD1: begin
            y_in = rd_ff;
            rd_addr = AW'(depth_ff - DW'(2));
            state_in = rpn_pkg::S_RD2;
         end
         rpn_pkg::S_RD2: begin
            rd_addr = AW'(depth_ff - DW'(2));
            state_in = rpn_pkg::S_EXEC;
         end
         // set up the operation, or finish add, subtract and negate here
         rpn_pkg::S_EXEC: begin
            x_in = rd_ff;
            state_in = rpn_pkg::S_WB;
            case (op_ff)
               rpn_pkg::OP_NEG: res_in = sat33(-{y_ff[31], y_ff});
               rpn_pkg::OP_ADD: res_in = sat33({rd_ff[31], rd_ff} + {y_ff[31], y_ff});
               rpn_pkg::OP_SUB: res_in = sat33({rd_ff[31], rd_ff} - {y_ff[31], y_ff});
               rpn_pkg::OP_MUL: begin
                  ua_in = mag(rd_ff); ub_in = ymag; dst_in = 2'd2;
                  neg_in = rd_ff[31] ^ y_ff[31];
                  state_in = rpn_pkg::S_MUL;
               end
               rpn_pkg::OP_DIV: begin
                  if (y_ff == '0) begin
                     err_in = rpn_pkg::ST_DIVZERO; state_in = rpn_pkg::S_RESP;
                  end else begin
                     neg_in = rd_ff[31] ^ y_ff[31];
                     num_in = mag(rd_ff) << FRAC_BITS; ub_in = ymag;
                     rem_in = '0; quo_in = '0; cnt_in = 7'd64;
                     state_in = rpn_pkg::S_DIV;
                  end
               end
               default: begin
                  exp_in = 32'(ymag >> FRAC_BITS);
                  recip_in = y_ff[31] && ((ymag >> FRAC_BITS) != 64'd0);
                  neg_in = rd_ff[31] && (ymag[FRAC_BITS] == 1'b1);
                  base_in = mag(rd_ff); acc_in = Q_ONE;
                  state_in = rpn_pkg::S_PSTEP;
               end
            endcase
         end
         // shared multiply result
         rpn_pkg::S_MUL: begin
            case (dst_ff)
               2'd0: begin acc_in = capped; state_in = rpn_pkg::S_PSTEP; end
               2'd1: begin base_in = capped; state_in = rpn_pkg::S_PSTEP; end
               default: begin res_in = sign_cap(neg_ff, mul_res); state_in = rpn_pkg::S_WB; end
            endcase
         end
         // one power step
         rpn_pkg::S_PSTEP: begin
            if (exp_ff == '0) begin
               state_in = rpn_pkg::S_PREC;
            end else if (exp_ff[0]) begin
               ua_in = acc_ff; ub_in = base_ff; dst_in = 2'd0;
               exp_in = {exp_ff[31:1], 1'b0};
               state_in = rpn_pkg::S_MUL;
            end else begin
               exp_in = exp_ff >> 1;
               if ((exp_ff >> 1) != '0) begin
                  ua_in = base_ff; ub_in = base_ff; dst_in = 2'd1;
                  state_in = rpn_pkg::S_MUL;
               end
            end
         end
         rpn_pkg::S_PREC: begin
            if (!recip_ff) begin
               res_in = sign_cap(neg_ff, acc_ff); state_in = rpn_pkg::S_WB;
            end else if (acc_ff == '0) begin
               err_in = rpn_pkg::ST_DIVZERO; state_in = rpn_pkg::S_RESP;
            end else begin
               num_in = Q_ONE << FRAC_BITS; ub_in = acc_ff;
               rem_in = '0; quo_in = '0; cnt_in = 7'd64;
               state_in = rpn_pkg::S_DIV;
            end
         end
         // restoring divider, one bit a cycle
         rpn_pkg::S_DIV: begin
            if (cnt_ff == '0) begin
               res_in = sign_cap(neg_ff, quo_ff); state_in = rpn_pkg::S_WB;
            end else begin
               num_in = num_ff << 1;
               if (rsh >= {1'b0, ub_ff}) begin
                  rem_in = rem_try; quo_in = {quo_ff[62:0], 1'b1};
               end else begin
                  rem_in = rsh[63:0]; quo_in = {quo_ff[62:0], 1'b0};
               end
               cnt_in = cnt_ff - 7'd1;
            end
         end
         // write the result or the pushed operand back
         rpn_pkg::S_WB: begin
            wr_en = 1'b1;
            if (op_ff == rpn_pkg::OP_PUSH) begin
               depth_in = depth_ff + DW'(1);
            end else if (op_ff == rpn_pkg::OP_NEG) begin
               wr_addr = AW'(depth_ff - DW'(1)); wr_data = res_ff;
            end else begin
               wr_addr = AW'(depth_ff - DW'(2)); wr_data = res_ff;
               depth_in = depth_ff - DW'(1);
            end
            rd_addr = '0;
            state_in = rpn_pkg::S_RESP;
         end
         // form the response once the output register is free
         default: begin
            rd_addr = '0;
            if (!ovalid_ff || rsp_tready) begin
               out_in = {5'd0, err_ff, 32'd0};
               if (last_ff) begin
                  if (err_ff != rpn_pkg::ST_OK) out_in = {5'd0, err_ff, 32'd0};
                  else if (depth_ff == DW'(1)) out_in = {5'd0, rpn_pkg::ST_ANSWER, rd_ff};
                  else out_in = {5'd0, rpn_pkg::ST_DEPTH, 32'd0};
                  depth_in = '0; err_in = rpn_pkg::ST_OK;
               end
               ovalid_in = 1'b1;
               state_in = rpn_pkg::S_IDLE;
            end
         end
      endcase
   end

   `ASSERT_ALWAYS(a_depth_range, clock, reset, 32'(depth_ff) <= STACK_DEPTH)
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   `ASSERT_NEXT(a_accept_busy, clock, reset, req_tvalid && req_tready, !req_tready)
   `ASSERT_ALWAYS(a_err_code, clock, reset,
      err_ff == rpn_pkg::ST_OK || err_ff == rpn_pkg::ST_DIVZERO ||
      err_ff == rpn_pkg::ST_OVERFLOW || err_ff == rpn_pkg::ST_UNDERFLOW)
endmodule
